// ===== hw/rtl/lacs_pkg.sv =====
// lacs_pkg: types and constants shared by the lamp command and alarm setter.
// No dependencies.
`default_nettype none

package lacs_pkg;

  localparam int unsigned MODE_COUNT = 7;

  localparam logic [2:0]  LEVEL_MAX     = 3'd4;
  localparam logic [3:0]  COLOR_MAX     = 4'd13;
  localparam logic [2:0]  MODE_NORMAL   = 3'd0;
  localparam logic [2:0]  MODE_COLOR    = 3'd3;
  localparam logic [2:0]  MODE_STUDY    = 3'd5;
  localparam logic [4:0]  HOUR_LAST     = 5'd23;
  localparam logic [5:0]  MINSEC_LAST   = 6'd59;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN  = 12'd60;
  localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
  localparam logic [15:0] TICKS_SAT     = 16'hFFFF;

  typedef enum logic [2:0] {
    REQ_SET        = 3'd0,
    REQ_LIGHT_UP   = 3'd1,
    REQ_LIGHT_DOWN = 3'd2,
    REQ_ALARM_ENTER = 3'd3,
    REQ_ALARM_INC  = 3'd4,
    REQ_ALARM_STEP = 3'd5,
    REQ_TICK       = 3'd6
  } req_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HOUR = 3'd1,
    PH_MIN  = 3'd2,
    PH_SEC  = 3'd3,
    PH_CONF = 3'd4
  } phase_e;

  typedef struct packed {
    req_e       req_type;
    logic [3:0] mode_req;
    logic [3:0] level_req;
    logic [3:0] color_req;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] level;
    logic [3:0] color;
    logic       study_start;
    logic       study_stop;
    logic       breath_restart;
  } lamp_res_t;

  typedef struct packed {
    phase_e      phase;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        fire;
    logic [16:0] seconds;
  } alarm_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lamp_command_and_alarm_setter.sv =====
// Lamp command and alarm setter: top level, input and result registers.
// Uses lacs_pkg, lacs_lamp and lacs_alarm.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request type,
//   tdata the set fields. Each request gives exactly one result on m_axis
//   holding the lamp state, alarm-setting phase, shown values and the event
//   flags (study start/stop, breath restart, alarm fire with its seconds).
//   cfg_* writes the setting timeout in ticks; it is always ready and should
//   be written only while no request is in flight.
// Path: an accepted request is registered in the input register, processed
//   by the lamp and alarm logic, and its result is registered in the result
//   register, from which m_axis offers it.
// Throughput: one request per cycle while results are taken, set by the
//   single input register and single result register.
// Reset: lamp mode normal, level 4, color 0, phase idle, all alarm values and
//   the idle tick count zero, timeout 10000; both channel stages empty.
// Stall: when the result is not taken, the held request waits in the input
//   register and s_axis_tready drops until the result register drains.
`default_nettype none

module lamp_command_and_alarm_setter import lacs_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  // request channel
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // mode_req[3:0], level_req[7:4], color_req[11:8], pad
  input  wire  [2:0]  s_axis_tuser,   // req_type[2:0]
  // result channel
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [55:0] m_axis_tdata,   // lamp_mode[2:0], lamp_level[5:3], lamp_color[9:6],
                                      // setting_phase[12:10], shown_hour[17:13],
                                      // shown_minute[23:18], shown_second[29:24],
                                      // alarm_fire[30], alarm_seconds[47:31],
                                      // study_start[48], study_stop[49],
                                      // breath_restart[50], pad
  // timeout register write
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [15:0] cfg_data_i
);

  logic        in_valid_q;
  cmd_t        cmd_q;
  logic        out_valid_q;
  logic [55:0] out_data_q;
  logic [15:0] timeout_q;
  logic        advance;
  logic        active;
  lamp_res_t   lamp_res;
  alarm_res_t  alarm_res;

  // request in the input register moves on when the result slot is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q.req_type  <= req_e'(s_axis_tuser);
      cmd_q.mode_req  <= s_axis_tdata[3:0];
      cmd_q.level_req <= s_axis_tdata[7:4];
      cmd_q.color_req <= s_axis_tdata[11:8];
    end
    if (advance) begin
      out_data_q <= {5'd0,
                     lamp_res.breath_restart, lamp_res.study_stop, lamp_res.study_start,
                     alarm_res.seconds, alarm_res.fire,
                     alarm_res.second, alarm_res.minute, alarm_res.hour,
                     3'(alarm_res.phase),
                     lamp_res.color, lamp_res.level, lamp_res.mode};
    end
  end

  lacs_lamp u_lamp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .active_i (active),
    .cmd_i    (cmd_q),
    .res_o    (lamp_res)
  );

  lacs_alarm u_alarm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .timeout_i (timeout_q),
    .cmd_i     (cmd_q),
    .active_o  (active),
    .res_o     (alarm_res)
  );

  // an alarm only fires on the confirm step, which always returns to idle
  a_fire_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[30]) |-> (m_axis_tdata[12:10] == PH_IDLE))
    else $error("alarm fired without returning to idle");

  // seconds are nonzero exactly when the alarm fires
  a_fire_secs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[30] == (m_axis_tdata[47:31] != 17'd0)))
    else $error("alarm seconds inconsistent with fire flag");

  // mode flags are mutually consistent with the reported mode
  a_study_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[48]) |-> (!m_axis_tdata[49] && m_axis_tdata[2:0] == MODE_STUDY))
    else $error("study start with wrong mode or stop flag");

  // input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled with free result slot");

  // a tick while idle never leaves idle
  a_tick_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !active && cmd_q.req_type == REQ_TICK) |=> (m_axis_tdata[12:10] == PH_IDLE))
    else $error("tick moved phase out of idle");

endmodule

`default_nettype wire

// ===== hw/rtl/lacs_lamp.sv =====
// lacs_lamp: lamp mode/level/color state with set, light up/down and mode flags.
// Depends on lacs_pkg.
`default_nettype none

module lacs_lamp import lacs_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        en_i,       // one request processed this cycle
  input  wire        active_i,   // alarm setting in progress, lamp requests dropped
  input  cmd_t       cmd_i,
  output lamp_res_t  res_o       // state after the request, plus flags
);

  logic [2:0] mode_q, mode_d;
  logic [2:0] level_q, level_d;
  logic [3:0] color_q, color_d;
  logic       apply;

  always_comb begin
    mode_d  = mode_q;
    level_d = level_q;
    color_d = color_q;
    apply   = 1'b0;
    if (!active_i) begin
      case (cmd_i.req_type)
        REQ_SET: begin
          apply   = 1'b1;
          mode_d  = (cmd_i.mode_req >= 4'(MODE_COUNT)) ? MODE_NORMAL : cmd_i.mode_req[2:0];
          level_d = (cmd_i.level_req > 4'(LEVEL_MAX)) ? 3'd0 : cmd_i.level_req[2:0];
          color_d = (cmd_i.color_req > COLOR_MAX) ? 4'd0 : cmd_i.color_req;
        end
        REQ_LIGHT_UP: begin
          apply   = 1'b1;
          level_d = (level_q >= LEVEL_MAX) ? LEVEL_MAX : level_q + 3'd1;
        end
        REQ_LIGHT_DOWN: begin
          apply   = 1'b1;
          level_d = (level_q == 3'd0) ? 3'd0 : level_q - 3'd1;
        end
        default: apply = 1'b0;
      endcase
    end
  end

  always_comb begin
    res_o.mode           = mode_d;
    res_o.level          = level_d;
    res_o.color          = color_d;
    res_o.study_start    = apply && (mode_d == MODE_STUDY) && (mode_q != MODE_STUDY);
    res_o.study_stop     = apply && (mode_d != MODE_STUDY);
    res_o.breath_restart = apply && (mode_d == MODE_COLOR) && (mode_q != MODE_COLOR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      level_q <= LEVEL_MAX;
      color_q <= 4'd0;
    end else if (en_i) begin
      mode_q  <= mode_d;
      level_q <= level_d;
      color_q <= color_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lacs_alarm.sv =====
// lacs_alarm: alarm-setting phase machine, set/display values, idle tick timeout.
// Depends on lacs_pkg.
`default_nettype none

module lacs_alarm import lacs_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         en_i,
  input  wire  [15:0] timeout_i,
  input  cmd_t        cmd_i,
  output logic        active_o,   // phase is not idle before this request
  output alarm_res_t  res_o
);

  phase_e      phase_q, phase_d;
  logic [4:0]  hour_q, hour_d, disp_hour_q, disp_hour_d;
  logic [5:0]  min_q, min_d, disp_min_q, disp_min_d;
  logic [5:0]  sec_q, sec_d, disp_sec_q, disp_sec_d;
  logic [15:0] ticks_q, ticks_d;
  logic [16:0] total;
  logic        sync;
  logic        fire;

  assign active_o = (phase_q != PH_IDLE);

  // 5x17 and 6x12 bit products, computed combinationally
  assign total = 17'(hour_q) * SECS_PER_HOUR + 17'(12'(min_q) * SECS_PER_MIN) + 17'(sec_q);

  always_comb begin
    phase_d = phase_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    ticks_d = ticks_q;
    sync    = 1'b0;
    fire    = 1'b0;
    if (phase_q != PH_IDLE) begin
      case (cmd_i.req_type)
        REQ_ALARM_INC: begin
          ticks_d = 16'd0;
          sync    = 1'b1;
          case (phase_q)
            PH_HOUR: hour_d = (hour_q == HOUR_LAST) ? 5'd0 : hour_q + 5'd1;
            PH_MIN:  min_d  = (min_q == MINSEC_LAST) ? 6'd0 : min_q + 6'd1;
            PH_SEC:  sec_d  = (sec_q == MINSEC_LAST) ? 6'd0 : sec_q + 6'd1;
            default: begin
              // increment at confirm cancels
              phase_d = PH_IDLE;
              sync    = 1'b0;
            end
          endcase
        end
        REQ_ALARM_STEP: begin
          ticks_d = 16'd0;
          if (phase_q == PH_CONF) begin
            phase_d = PH_IDLE;
            fire    = (total != 17'd0);
          end else begin
            phase_d = phase_e'(phase_q + 3'd1);
            sync    = 1'b1;
          end
        end
        REQ_TICK: begin
          ticks_d = (ticks_q == TICKS_SAT) ? ticks_q : ticks_q + 16'd1;
          if (ticks_d >= timeout_i) phase_d = PH_IDLE;
        end
        default: phase_d = phase_q;
      endcase
    end else if (cmd_i.req_type == REQ_ALARM_ENTER) begin
      phase_d = PH_HOUR;
      hour_d  = 5'd0;
      min_d   = 6'd0;
      sec_d   = 6'd0;
      ticks_d = 16'd0;
      sync    = 1'b1;
    end
  end

  assign disp_hour_d = sync ? hour_d : disp_hour_q;
  assign disp_min_d  = sync ? min_d  : disp_min_q;
  assign disp_sec_d  = sync ? sec_d  : disp_sec_q;

  always_comb begin
    res_o.phase   = phase_d;
    res_o.hour    = disp_hour_d;
    res_o.minute  = disp_min_d;
    res_o.second  = disp_sec_d;
    res_o.fire    = fire;
    res_o.seconds = fire ? total : 17'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      hour_q      <= 5'd0;
      min_q       <= 6'd0;
      sec_q       <= 6'd0;
      disp_hour_q <= 5'd0;
      disp_min_q  <= 6'd0;
      disp_sec_q  <= 6'd0;
      ticks_q     <= 16'd0;
    end else if (en_i) begin
      phase_q     <= phase_d;
      hour_q      <= hour_d;
      min_q       <= min_d;
      sec_q       <= sec_d;
      disp_hour_q <= disp_hour_d;
      disp_min_q  <= disp_min_d;
      disp_sec_q  <= disp_sec_d;
      ticks_q     <= ticks_d;
    end
  end

endmodule

`default_nettype wire
